/* sv/pan_tilt_tracker_azimuth_gate_defines.svh */
// assertion macros for the azimuth gate
`ifndef PAN_TILT_TRACKER_AZIMUTH_GATE_DEFINES_SVH
`define PAN_TILT_TRACKER_AZIMUTH_GATE_DEFINES_SVH

// same-cycle implication
`define PTAG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PTAG_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/ptag_pkg.sv */
package ptag_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int SCALE_BITS  = 24;
	localparam int CW          = COORD_WIDTH + SCALE_BITS + 2;
	localparam int ZW          = 24;
	localparam int DW          = 19;
	localparam int HVA_WIDTH   = 15;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	localparam logic [HVA_WIDTH-1:0] HVA_RESET = 15'd4506;
	localparam logic signed [DW-1:0] FULL_TURN = 19'sd46080;
	localparam logic signed [DW-1:0] HALF_TURN = 19'sd23040;
	localparam logic signed [ZW-1:0] QUARTER_Q14 = 24'sd1474560;
	localparam logic [20:0] HP_OFFSET = 21'd737280;

	localparam logic KIND_POINT = 1'b0;
	localparam logic KIND_POSE  = 1'b1;

	typedef enum logic [1:0] {
		MODE_CMD   = 2'd0,
		MODE_TICK  = 2'd1,
		MODE_POINT = 2'd2
	} mode_t;

	typedef enum logic [7:0] {
		CMD_STOP     = 8'h00,
		CMD_RIGHT    = 8'h02,
		CMD_LEFT     = 8'h04,
		CMD_UP       = 8'h08,
		CMD_DOWN     = 8'h10,
		CMD_ABS_PAN  = 8'h4B,
		CMD_ABS_TILT = 8'h4D
	} cmd_code_t;

	typedef enum logic [1:0] {
		FS_IDLE,
		FS_SUM,
		FS_WRAP
	} front_state_t;

	typedef struct packed {
		logic [1:0]                     mode;
		logic [7:0]                     command_code;
		logic signed [23:0]             command_value;
		logic [15:0]                    elapsed_ticks;
		logic signed [COORD_WIDTH-1:0]  point_x;
		logic signed [COORD_WIDTH-1:0]  point_y;
		logic signed [COORD_WIDTH-1:0]  point_z;
		logic [15:0]                    point_intensity;
		logic                           point_valid;
	} item_t;

	typedef struct packed {
		logic                           result_kind;
		logic signed [COORD_WIDTH-1:0]  out_x;
		logic signed [COORD_WIDTH-1:0]  out_y;
		logic signed [COORD_WIDTH-1:0]  out_z;
		logic [15:0]                    out_intensity;
		logic [15:0]                    pan_angle;
		logic [15:0]                    tilt_angle;
	} result_t;

	// remainder by 45 through a reciprocal multiply and one correction
	function automatic logic [5:0] mod45(input logic [20:0] hp);
		logic [42:0] prod;
		logic [15:0] q;
		logic [21:0] r;
		prod = {22'd0, hp} * 43'd2982617;
		q = prod[42:27];
		r = {1'b0, hp} - 22'({6'd0, q} * 22'd45);
		if (r >= 22'd45) begin
			r = r - 22'd45;
		end
		return r[5:0];
	endfunction

	// atan(2^-i) in 1/16384 degree
	function automatic logic signed [ZW-1:0] atan_q14(input logic [4:0] idx);
		logic signed [ZW-1:0] a;
		case (idx)
			5'd0: a = 24'sd737280;
			5'd1: a = 24'sd435242;
			5'd2: a = 24'sd229970;
			5'd3: a = 24'sd116736;
			5'd4: a = 24'sd58595;
			5'd5: a = 24'sd29326;
			5'd6: a = 24'sd14667;
			5'd7: a = 24'sd7334;
			5'd8: a = 24'sd3667;
			5'd9: a = 24'sd1833;
			5'd10: a = 24'sd917;
			5'd11: a = 24'sd458;
			5'd12: a = 24'sd229;
			5'd13: a = 24'sd115;
			5'd14: a = 24'sd57;
			5'd15: a = 24'sd29;
			5'd16: a = 24'sd14;
			5'd17: a = 24'sd7;
			5'd18: a = 24'sd4;
			5'd19: a = 24'sd2;
			5'd20: a = 24'sd1;
			default: a = 24'sd0;
		endcase
		return a;
	endfunction

endpackage

/* sv/pan_tilt_tracker_azimuth_gate.sv */
// a point item passes from the queue through the CORDIC stages to the result register
// a tick item first goes through the angle wrap unit (sum state, then wrap state), then the same path
// throughput: one point or rate command per cycle while the queue has room; tick and absolute
// angle items hold the input while the shared wrap unit reduces the angles modulo a full turn
// reset: asynchronous, angles and rates go to zero, half view angle to 35.2 degrees
module pan_tilt_tracker_azimuth_gate import ptag_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  item_t                item,
	output logic                 empty,
	input  logic                 pop,
	output result_t              result,
	input  logic                 cfg_wr_en,
	input  logic [HVA_WIDTH-1:0] cfg_wr_data
);

	logic [HVA_WIDTH-1:0] hva_q;
	logic                 q_push, q_full, q_pop, q_empty;
	result_t              q_wdata, q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hva_q <= HVA_RESET;
		end else if (cfg_wr_en) begin
			hva_q <= cfg_wr_data;
		end
	end

	ptag_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_wdata)
	);

	ptag_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.rd     (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	ptag_gate #(
		.STEPS (CORDIC_STEPS)
	) u_gate (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_rdata),
		.q_pop   (q_pop),
		.hva     (hva_q),
		.result  (result),
		.empty   (empty),
		.pop     (pop)
	);

endmodule

/* sv/ptag_front.sv */
module ptag_front import ptag_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  item_t   item,
	input  logic    q_full,
	output logic    q_push,
	output result_t q_data
);

	front_state_t state_q, state_d;

	logic signed [23:0] yaw_rate_q, pitch_rate_q;
	logic [15:0]        yaw_q, pitch_q;

	logic signed [39:0] yprod_s1, pprod_s1;
	logic signed [33:0] ybase_s1, pbase_s1;
	logic               tick_s1;
	logic [20:0]        yhp_s2, php_s2;
	logic [9:0]         ylo_s2, plo_s2;

	logic               accept, is_cmd, is_tick, is_abs_pan, is_abs_tilt;
	logic signed [23:0] nval, ysrc, psrc;
	logic signed [40:0] ysum, psum;
	logic [15:0]        new_yaw, new_pitch;
	logic               wrap_done;

	assign full        = (state_q != FS_IDLE) || q_full;
	assign accept      = push && !full;
	assign is_cmd      = item.mode == MODE_CMD;
	assign is_tick     = item.mode == MODE_TICK;
	assign is_abs_pan  = is_cmd && (item.command_code == CMD_ABS_PAN);
	assign is_abs_tilt = is_cmd && (item.command_code == CMD_ABS_TILT);
	assign nval        = (item.command_value == 24'sh800000) ? 24'sh7FFFFF
		: -item.command_value;
	assign ysrc        = is_abs_pan ? item.command_value : $signed({8'd0, yaw_q});
	assign psrc        = is_abs_tilt ? item.command_value : $signed({8'd0, pitch_q});

	assign ysum = {{7{ybase_s1[33]}}, ybase_s1} + {yprod_s1[39], yprod_s1};
	assign psum = {{7{pbase_s1[33]}}, pbase_s1} + {pprod_s1[39], pprod_s1};

	assign new_yaw   = {mod45(yhp_s2), ylo_s2};
	assign new_pitch = {mod45(php_s2), plo_s2};
	assign wrap_done = (state_q == FS_WRAP) && (!tick_s1 || !q_full);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		q_push  = 1'b0;
		q_data  = '{result_kind: KIND_POINT, out_x: item.point_x, out_y: item.point_y,
			out_z: item.point_z, out_intensity: item.point_intensity,
			pan_angle: yaw_q, tilt_angle: pitch_q};
		case (state_q)
			FS_IDLE: begin
				if (accept) begin
					if (is_tick || is_abs_pan || is_abs_tilt) begin
						state_d = FS_SUM;
					end
					q_push = (item.mode == MODE_POINT) && item.point_valid;
				end
			end
			FS_SUM: begin
				state_d = FS_WRAP;
			end
			FS_WRAP: begin
				q_data = '{result_kind: KIND_POSE, out_x: '0, out_y: '0, out_z: '0,
					out_intensity: '0, pan_angle: new_yaw, tilt_angle: new_pitch};
				q_push = tick_s1 && !q_full;
				if (wrap_done) begin
					state_d = FS_IDLE;
				end
			end
			default: begin
				state_d = FS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_rate_q   <= '0;
			pitch_rate_q <= '0;
			yaw_q        <= '0;
			pitch_q      <= '0;
		end else begin
			if (accept && is_cmd) begin
				case (item.command_code)
					CMD_STOP: begin
						yaw_rate_q   <= '0;
						pitch_rate_q <= '0;
					end
					CMD_RIGHT:    yaw_rate_q   <= item.command_value;
					CMD_LEFT:     yaw_rate_q   <= nval;
					CMD_UP:       pitch_rate_q <= item.command_value;
					CMD_DOWN:     pitch_rate_q <= nval;
					CMD_ABS_PAN:  yaw_rate_q   <= '0;
					CMD_ABS_TILT: pitch_rate_q <= '0;
					default: begin
					end
				endcase
			end
			if (wrap_done) begin
				yaw_q   <= new_yaw;
				pitch_q <= new_pitch;
			end
		end
	end

	// angle * 1024 + rate * dt + 512, then split off the turn count
	always_ff @(posedge clk) begin
		if (accept) begin
			tick_s1  <= is_tick;
			ybase_s1 <= $signed({ysrc, 10'h200});
			pbase_s1 <= $signed({psrc, 10'h200});
			yprod_s1 <= is_tick ? 40'(yaw_rate_q * $signed({1'b0, item.elapsed_ticks}))
				: '0;
			pprod_s1 <= is_tick ? 40'(pitch_rate_q * $signed({1'b0, item.elapsed_ticks}))
				: '0;
		end
		if (state_q == FS_SUM) begin
			yhp_s2 <= ysum[40:20] + HP_OFFSET;
			php_s2 <= psum[40:20] + HP_OFFSET;
			ylo_s2 <= ysum[19:10];
			plo_s2 <= psum[19:10];
		end
	end

endmodule

/* sv/ptag_fifo.sv */
module ptag_fifo import ptag_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr,
	input  result_t wdata,
	output logic    full,
	input  logic    rd,
	output result_t rdata,
	output logic    empty
);

	result_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QPTR_W:0]   count_q;

	assign full  = count_q == (QPTR_W + 1)'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			count_q <= count_q + (QPTR_W + 1)'(wr) - (QPTR_W + 1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

/* sv/ptag_gate.sv */
`include "pan_tilt_tracker_azimuth_gate_defines.svh"

module ptag_gate import ptag_pkg::*; #(
	parameter int STEPS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  result_t              q_data,
	output logic                 q_pop,
	input  logic [HVA_WIDTH-1:0] hva,
	output result_t              result,
	output logic                 empty,
	input  logic                 pop
);

	logic                 valid_s  [STEPS+1];
	result_t              rec_s    [STEPS+1];
	logic                 origin_s [STEPS+1];
	logic signed [CW-1:0] cx_s     [STEPS+1];
	logic signed [CW-1:0] cy_s     [STEPS+1];
	logic signed [ZW-1:0] cz_s     [STEPS+1];

	logic                 out_valid_q;
	result_t              result_q;
	logic                 enable;

	logic signed [CW-1:0] xs, ys, x0, y0;
	logic signed [ZW-1:0] z0, zr;
	logic signed [16:0]   az;
	logic signed [DW-1:0] diff, dabs;
	logic                 pass;

	logic                 pose_last, pose_out, pose_blank;

	assign enable = !out_valid_q || pop;
	assign q_pop  = enable && !q_empty;
	assign empty  = !out_valid_q;
	assign result = result_q;

	assign pose_last  = valid_s[STEPS] && (rec_s[STEPS].result_kind == KIND_POSE);
	assign pose_out   = out_valid_q && (result_q.result_kind == KIND_POSE);
	assign pose_blank = (result_q.out_x == '0) && (result_q.out_intensity == '0);

	// scale by 2^24 and rotate into the right half plane
	always_comb begin
		xs = {{(CW-COORD_WIDTH-SCALE_BITS){q_data.out_x[COORD_WIDTH-1]}}, q_data.out_x,
			{SCALE_BITS{1'b0}}};
		ys = {{(CW-COORD_WIDTH-SCALE_BITS){q_data.out_y[COORD_WIDTH-1]}}, q_data.out_y,
			{SCALE_BITS{1'b0}}};
		x0 = xs;
		y0 = ys;
		z0 = '0;
		if (xs < 0) begin
			if (ys >= 0) begin
				x0 = ys;
				y0 = -xs;
				z0 = QUARTER_Q14;
			end else begin
				x0 = -ys;
				y0 = xs;
				z0 = -QUARTER_Q14;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= STEPS; i++) begin
				valid_s[i] <= 1'b0;
			end
			out_valid_q <= 1'b0;
		end else if (enable) begin
			valid_s[0] <= !q_empty;
			for (int i = 0; i < STEPS; i++) begin
				valid_s[i+1] <= valid_s[i];
			end
			out_valid_q <= valid_s[STEPS] && (rec_s[STEPS].result_kind == KIND_POSE || pass);
		end
	end

	always_ff @(posedge clk) begin
		if (enable) begin
			rec_s[0]    <= q_data;
			origin_s[0] <= (q_data.out_x == '0) && (q_data.out_y == '0);
			cx_s[0]     <= x0;
			cy_s[0]     <= y0;
			cz_s[0]     <= z0;
			for (int i = 0; i < STEPS; i++) begin
				rec_s[i+1]    <= rec_s[i];
				origin_s[i+1] <= origin_s[i];
				if (cy_s[i] >= 0) begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] + atan_q14(5'(i));
				end else begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] - atan_q14(5'(i));
				end
			end
			result_q <= rec_s[STEPS];
		end
	end

	// azimuth to 1/128 degree, offset to yaw wrapped into half a turn
	always_comb begin
		zr   = cz_s[STEPS] + 24'sd64;
		az   = origin_s[STEPS] ? 17'sd0 : zr[ZW-1:7];
		diff = $signed({{(DW-17){az[16]}}, az})
			- $signed({{(DW-16){1'b0}}, rec_s[STEPS].pan_angle});
		if (diff > HALF_TURN) begin
			diff = diff - FULL_TURN;
		end
		if (diff < -HALF_TURN) begin
			diff = diff + FULL_TURN;
		end
		dabs = (diff < 0) ? -diff : diff;
		pass = dabs <= $signed({{(DW-HVA_WIDTH){1'b0}}, hva});
	end

	`PTAG_ASSERT_NXT(a_pose_kept, pose_last && enable, out_valid_q, "pose item lost in gate")
	`PTAG_ASSERT_IMP(a_pose_clear, pose_out, pose_blank, "pose item carries point data")
	`PTAG_ASSERT_NXT(a_hold, out_valid_q && !pop, out_valid_q && $stable(result_q), "waiting item changed")

endmodule
